// File: src/sfdc_pkg.sv
package sfdc_pkg;

  // Payload store depth; the length field of a frame may not exceed it.
  localparam int unsigned MaxPayload = 64;
  localparam int unsigned AddrW      = $clog2(MaxPayload);

  // Register reset values
  localparam logic [7:0]  HeaderFirstRst   = 8'hA5;
  localparam logic [7:0]  HeaderSecondRst  = 8'h5A;
  localparam logic [7:0]  TrailerFirstRst  = 8'h0D;
  localparam logic [7:0]  TrailerSecondRst = 8'h0A;
  localparam logic        CrcCheckEnRst    = 1'b1;
  localparam logic [15:0] CrcPolyRst       = 16'hA001;
  localparam logic [15:0] CrcInitRst       = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_HEADER_FIRST   = 3'd0,
    REG_HEADER_SECOND  = 3'd1,
    REG_TRAILER_FIRST  = 3'd2,
    REG_TRAILER_SECOND = 3'd3,
    REG_CRC_CHECK_EN   = 3'd4,
    REG_CRC_POLY       = 3'd5,
    REG_CRC_INIT       = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACT_RX_BYTE = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_READ    = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ACCEPT   = 3'd1,
    EV_CRC_BAD  = 3'd2,
    EV_TRAILER  = 3'd3,
    EV_IGNORED  = 3'd4,
    EV_TOO_LONG = 3'd5
  } event_e;

  typedef enum logic [3:0] {
    PH_HEAD0 = 4'd0,
    PH_HEAD1 = 4'd1,
    PH_ID    = 4'd2,
    PH_LEN   = 4'd3,
    PH_DATA  = 4'd4,
    PH_CRC0  = 4'd5,
    PH_CRC1  = 4'd6,
    PH_END0  = 4'd7,
    PH_END1  = 4'd8
  } phase_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic        frame_ready;
    logic [7:0]  frame_tag;
    logic [6:0]  frame_length;
    logic [7:0]  read_data;
    logic [15:0] received_crc;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [7:0]  trailer_first;
    logic [7:0]  trailer_second;
    logic        crc_check_en;
    logic [15:0] crc_poly;
    logic [15:0] crc_init;
  } cfg_t;

  // Payload store write request from the parser
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  // Parser result for one item, minus the payload read data
  typedef struct packed {
    logic [2:0]  event_res;
    logic        frame_ready;
    logic [7:0]  frame_tag;
    logic [6:0]  frame_length;
    logic [15:0] received_crc;
    logic        read_hit;
  } parse_res_t;

endpackage

// File: src/serial_frame_deframer_crc16_unit.sv
// Frame deframer for a received byte stream. Frames are: header byte one,
// header byte two, frame id, payload length, payload, CRC-16 low byte, CRC-16
// high byte, trailer byte one, trailer byte two. The payload lands in a
// 64-byte store while a reflected CRC-16 (polynomial and start value set by
// registers) runs over it; an accepted frame sets frame_ready and further
// bytes are reported as ignored until an acknowledge item. Read items fetch
// stored payload bytes (0 past the frame length). Every item gives exactly
// one result. Rate: one item per clock while out_ready_i does not stall the
// output; each item passes through the input register, then the result
// register together with the registered payload-store read.
// Configuration writes are always accepted (cfg_ready_o tied high) and
// should only be issued while no item is in flight.
module serial_frame_deframer_crc16_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sfdc_pkg::in_item_t   in_item_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sfdc_pkg::out_item_t  out_item_o,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import sfdc_pkg::*;

  cfg_t       cfg;
  mem_wr_t    mem_wr;
  parse_res_t parse_res;
  logic [7:0] mem_rd_data;

  // stage 1: input register
  logic       s1_valid_q;
  in_item_t   s1_item_q;
  logic       s1_adv;

  // stage 2: result register
  logic       out_valid_q;
  parse_res_t res_q;

  assign cfg_ready_o = 1'b1;

  // Item moves to the result register whenever that slot is free or draining.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= parse_res;
    end
  end

  sfdc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  sfdc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .mem_wr_o (mem_wr),
    .res_o    (parse_res)
  );

  // Read data is captured on the same edge as res_q, so it belongs to
  // the item held in the result register.
  sfdc_payload_mem u_payload_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_en_i   (s1_adv),
    .rd_addr_i (s1_item_q.read_index),
    .rd_data_o (mem_rd_data)
  );

  assign out_valid_o             = out_valid_q;
  assign out_item_o.event_res    = res_q.event_res;
  assign out_item_o.frame_ready  = res_q.frame_ready;
  assign out_item_o.frame_tag    = res_q.frame_tag;
  assign out_item_o.frame_length = res_q.frame_length;
  assign out_item_o.read_data    = res_q.read_hit ? mem_rd_data : 8'h00;
  assign out_item_o.received_crc = res_q.received_crc;

endmodule

// File: src/sfdc_cfg_regs.sv
module sfdc_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [2:0]    wr_index_i,
  input  logic [15:0]   wr_data_i,
  output sfdc_pkg::cfg_t cfg_o
);
  import sfdc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        REG_HEADER_FIRST:   cfg_d.header_first   = wr_data_i[7:0];
        REG_HEADER_SECOND:  cfg_d.header_second  = wr_data_i[7:0];
        REG_TRAILER_FIRST:  cfg_d.trailer_first  = wr_data_i[7:0];
        REG_TRAILER_SECOND: cfg_d.trailer_second = wr_data_i[7:0];
        REG_CRC_CHECK_EN:   cfg_d.crc_check_en   = wr_data_i[0];
        REG_CRC_POLY:       cfg_d.crc_poly       = wr_data_i;
        REG_CRC_INIT:       cfg_d.crc_init       = wr_data_i;
        default:            cfg_d = cfg_q;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first   <= HeaderFirstRst;
      cfg_q.header_second  <= HeaderSecondRst;
      cfg_q.trailer_first  <= TrailerFirstRst;
      cfg_q.trailer_second <= TrailerSecondRst;
      cfg_q.crc_check_en   <= CrcCheckEnRst;
      cfg_q.crc_poly       <= CrcPolyRst;
      cfg_q.crc_init       <= CrcInitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/sfdc_payload_mem.sv
module sfdc_payload_mem (
  input  logic                        clk_i,
  input  sfdc_pkg::mem_wr_t           wr_i,
  input  logic                        rd_en_i,
  input  logic [sfdc_pkg::AddrW-1:0]  rd_addr_i,
  output logic [7:0]                  rd_data_o
);
  import sfdc_pkg::*;

  logic [7:0] mem [MaxPayload];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/sfdc_parser.sv
module sfdc_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  sfdc_pkg::in_item_t    item_i,
  input  sfdc_pkg::cfg_t        cfg_i,
  output sfdc_pkg::mem_wr_t     mem_wr_o,
  output sfdc_pkg::parse_res_t  res_o
);
  import sfdc_pkg::*;

  phase_e      phase_q, phase_d;
  logic        ready_q, ready_d;
  logic [7:0]  id_q, id_d;
  logic [6:0]  len_q, len_d;
  logic [6:0]  pos_q, pos_d;
  logic [15:0] crc_rx_q, crc_rx_d;
  logic [15:0] crc_run_q, crc_run_d;
  logic [2:0]  event_d;

  logic        take_byte;
  logic [7:0]  b;
  logic [6:0]  pos_inc;
  logic        len_too_big;
  logic        crc_ok;

  // Reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] crc_feed(logic [15:0] crc_in, logic [7:0] data,
                                           logic [15:0] poly);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

  assign b           = item_i.rx_byte;
  assign take_byte   = step_i && (item_i.action == ACT_RX_BYTE) && !ready_q;
  assign pos_inc     = pos_q + 7'd1;
  assign len_too_big = b > 8'(MaxPayload);
  assign crc_ok      = !cfg_i.crc_check_en || (crc_run_q == crc_rx_q);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (take_byte) begin
      unique case (phase_q)
        PH_HEAD0: if (b == cfg_i.header_first) phase_d = PH_HEAD1;
        PH_HEAD1: phase_d = (b == cfg_i.header_second) ? PH_ID : PH_HEAD0;
        PH_ID:    phase_d = PH_LEN;
        PH_LEN: begin
          if (len_too_big)   phase_d = PH_HEAD0;
          else if (b == '0)  phase_d = PH_CRC0;
          else               phase_d = PH_DATA;
        end
        PH_DATA:  if (pos_inc >= len_q) phase_d = PH_CRC0;
        PH_CRC0:  phase_d = PH_CRC1;
        PH_CRC1:  phase_d = PH_END0;
        PH_END0:  phase_d = (b == cfg_i.trailer_first) ? PH_END1 : PH_HEAD0;
        PH_END1:  phase_d = PH_HEAD0;
        default:  phase_d = PH_HEAD0;
      endcase
    end
  end

  // Datapath and event per phase
  always_comb begin
    ready_d   = ready_q;
    id_d      = id_q;
    len_d     = len_q;
    pos_d     = pos_q;
    crc_rx_d  = crc_rx_q;
    crc_run_d = crc_run_q;
    event_d   = EV_NONE;
    mem_wr_o.we   = 1'b0;
    mem_wr_o.addr = pos_q[AddrW-1:0];
    mem_wr_o.data = b;

    if (step_i && (item_i.action == ACT_ACK)) begin
      ready_d = 1'b0;
    end else if (step_i && (item_i.action == ACT_RX_BYTE) && ready_q) begin
      event_d = EV_IGNORED;
    end else if (take_byte) begin
      unique case (phase_q)
        PH_ID: id_d = b;
        PH_LEN: begin
          if (len_too_big) begin
            event_d = EV_TOO_LONG;
          end else begin
            len_d     = b[6:0];
            pos_d     = '0;
            crc_run_d = cfg_i.crc_init;
          end
        end
        PH_DATA: begin
          mem_wr_o.we = pos_q < 7'(MaxPayload);
          crc_run_d   = crc_feed(crc_run_q, b, cfg_i.crc_poly);
          pos_d       = pos_inc;
        end
        PH_CRC0: crc_rx_d = {crc_rx_q[15:8], b};
        PH_CRC1: crc_rx_d = {b, crc_rx_q[7:0]};
        PH_END0: if (b != cfg_i.trailer_first) event_d = EV_TRAILER;
        PH_END1: begin
          if (b != cfg_i.trailer_second) begin
            event_d = EV_TRAILER;
          end else if (!crc_ok) begin
            event_d = EV_CRC_BAD;
          end else begin
            event_d = EV_ACCEPT;
            ready_d = 1'b1;
          end
        end
        default: event_d = EV_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEAD0;
      ready_q   <= 1'b0;
      id_q      <= '0;
      len_q     <= '0;
      pos_q     <= '0;
      crc_rx_q  <= '0;
      crc_run_q <= CrcInitRst;
    end else begin
      phase_q   <= phase_d;
      ready_q   <= ready_d;
      id_q      <= id_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      crc_rx_q  <= crc_rx_d;
      crc_run_q <= crc_run_d;
    end
  end

  assign res_o.event_res    = event_d;
  assign res_o.frame_ready  = ready_d;
  assign res_o.frame_tag    = id_d;
  assign res_o.frame_length = len_d;
  assign res_o.received_crc = crc_rx_d;
  assign res_o.read_hit     = (item_i.action == ACT_READ) &&
                              ({1'b0, item_i.read_index} < len_q);

endmodule

// File: src/sfdc_checker.sv
module sfdc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input sfdc_pkg::out_item_t  out_item_o
);
  import sfdc_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // An accepted frame always shows the ready flag set
  a_accept_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.event_res == EV_ACCEPT) |-> out_item_o.frame_ready)
    else $error("frame accepted without ready flag");

  // Bytes are only ignored while a frame waits for acknowledge
  a_ignored_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.event_res == EV_IGNORED) |-> out_item_o.frame_ready)
    else $error("byte ignored with no frame pending");

  // Stored length never exceeds the payload store
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.frame_length <= 7'(MaxPayload))
    else $error("frame length beyond payload store");

endmodule

bind serial_frame_deframer_crc16_unit sfdc_checker u_sfdc_checker (.*);
